// ===== rtl/ubx_pkg.sv =====
// ----------------------------------------------------------------------------
// ubx_pkg
// shared types and constants for the ubx frame parser: parse phases,
// result kinds, sync characters and the result record
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam logic [7:0]  SYNC_CHAR_1 = 8'hB5;
  localparam logic [7:0]  SYNC_CHAR_2 = 8'h62;
  localparam logic [15:0] LIMIT_RESET = 16'd100;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  // parse phases, one-hot
  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b0_0000_0001,
    PH_SYNC2   = 9'b0_0000_0010,
    PH_CLASS   = 9'b0_0000_0100,
    PH_MSG     = 9'b0_0000_1000,
    PH_LEN_LO  = 9'b0_0001_0000,
    PH_LEN_HI  = 9'b0_0010_0000,
    PH_PAYLOAD = 9'b0_0100_0000,
    PH_CHECK1  = 9'b0_1000_0000,
    PH_CHECK2  = 9'b1_0000_0000
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] frame_length;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        checksum_ok;
  } result_t;

endpackage

// ===== rtl/ubx_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ubx_frame_parser
// finds ubx frames in a byte stream and reports header, payload bytes and
// frame end with fletcher-8 checksum status
// ----------------------------------------------------------------------------
// One received byte is taken per item, so the block sustains one item per
// cycle while in_ready is high. The parse phase, the frame fields and the
// two 8-bit fletcher sums update at the edge the byte is accepted; a result
// produced by that byte is loaded at the same edge into the output register,
// which drives the out_ channel, or into a second (skid) register when the
// output register holds a result not being taken; in_ready only drops when
// both hold results the consumer has not taken. Results: header (or reject,
// when not synchronized and the length exceeds the limit) on the second
// length byte, one item per payload byte, and a frame-end item on the second
// checksum byte. The limit register is written through cfg_wr_en/cfg_wr_data;
// write it only while the block is idle, which the block does not enforce.
module ubx_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_msg_class,
  output logic [7:0]  out_msg_id,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic        out_checksum_ok
);

  // parser state
  ubx_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      class_r, class_nxt;
  logic [7:0]      msg_r, msg_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [15:0]     pos_r, pos_nxt;
  logic [7:0]      sum_a_r, sum_a_nxt;
  logic [7:0]      sum_b_r, sum_b_nxt;
  logic [7:0]      chk1_r, chk1_nxt;
  logic            synced_r, synced_nxt;
  logic [15:0]     limit_r;

  logic             acc;
  logic             can_push;
  logic             res_push;
  ubx_pkg::result_t res;
  ubx_pkg::result_t out_res;
  logic [15:0]      len_hi_val;
  logic [16:0]      pos_inc;
  logic [7:0]       fa_a;      // running sum_a after adding the byte
  logic             ck_ok;

  assign in_ready   = can_push;
  assign acc        = in_valid && in_ready;
  assign len_hi_val = {in_rx_byte, len_r[7:0]};
  assign pos_inc    = {1'b0, pos_r} + 17'd1;
  assign fa_a       = sum_a_r + in_rx_byte;
  assign ck_ok      = (chk1_r == sum_a_r) && (in_rx_byte == sum_b_r);

  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    msg_nxt    = msg_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    chk1_nxt   = chk1_r;
    synced_nxt = synced_r;
    res_push   = 1'b0;
    res        = '0;
    res.msg_class    = class_r;
    res.msg_id       = msg_r;
    res.frame_length = len_r;

    if (acc) begin
      unique case (phase_r)
        ubx_pkg::PH_SYNC2: begin
          phase_nxt = (in_rx_byte == ubx_pkg::SYNC_CHAR_2) ? ubx_pkg::PH_CLASS
                                                           : ubx_pkg::PH_SYNC1;
        end
        ubx_pkg::PH_CLASS: begin
          // sums restart with the class byte
          class_nxt = in_rx_byte;
          sum_a_nxt = in_rx_byte;
          sum_b_nxt = in_rx_byte;
          phase_nxt = ubx_pkg::PH_MSG;
        end
        ubx_pkg::PH_MSG: begin
          msg_nxt   = in_rx_byte;
          sum_a_nxt = fa_a;
          sum_b_nxt = sum_b_r + fa_a;
          phase_nxt = ubx_pkg::PH_LEN_LO;
        end
        ubx_pkg::PH_LEN_LO: begin
          len_nxt   = {8'd0, in_rx_byte};
          sum_a_nxt = fa_a;
          sum_b_nxt = sum_b_r + fa_a;
          phase_nxt = ubx_pkg::PH_LEN_HI;
        end
        ubx_pkg::PH_LEN_HI: begin
          len_nxt   = len_hi_val;
          pos_nxt   = '0;
          sum_a_nxt = fa_a;
          sum_b_nxt = sum_b_r + fa_a;
          res_push  = 1'b1;
          res.frame_length = len_hi_val;
          if (!synced_r && (len_hi_val > limit_r)) begin
            res.kind  = ubx_pkg::KIND_REJECT;
            phase_nxt = ubx_pkg::PH_SYNC1;
          end else begin
            res.kind  = ubx_pkg::KIND_HEADER;
            phase_nxt = (len_hi_val != 16'd0) ? ubx_pkg::PH_PAYLOAD
                                              : ubx_pkg::PH_CHECK1;
          end
        end
        ubx_pkg::PH_PAYLOAD: begin
          res_push          = 1'b1;
          res.kind          = ubx_pkg::KIND_PAYLOAD;
          res.payload_byte  = in_rx_byte;
          res.payload_index = pos_r;
          sum_a_nxt = fa_a;
          sum_b_nxt = sum_b_r + fa_a;
          pos_nxt   = pos_inc[15:0];
          if (pos_inc >= {1'b0, len_r}) phase_nxt = ubx_pkg::PH_CHECK1;
        end
        ubx_pkg::PH_CHECK1: begin
          chk1_nxt  = in_rx_byte;
          phase_nxt = ubx_pkg::PH_CHECK2;
        end
        ubx_pkg::PH_CHECK2: begin
          synced_nxt      = ck_ok;
          res_push        = 1'b1;
          res.kind        = ubx_pkg::KIND_END;
          res.checksum_ok = ck_ok;
          phase_nxt       = ubx_pkg::PH_SYNC1;
        end
        default: begin
          // hunting for the first sync byte
          phase_nxt = (in_rx_byte == ubx_pkg::SYNC_CHAR_1) ? ubx_pkg::PH_SYNC2
                                                           : ubx_pkg::PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ubx_pkg::PH_SYNC1;
      class_r  <= '0;
      msg_r    <= '0;
      len_r    <= '0;
      pos_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      chk1_r   <= '0;
      synced_r <= 1'b0;
      limit_r  <= ubx_pkg::LIMIT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      msg_r    <= msg_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      chk1_r   <= chk1_nxt;
      synced_r <= synced_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
    end
  end

  // output register and skid stage
  ubx_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_msg_class     = out_res.msg_class;
  assign out_msg_id        = out_res.msg_id;
  assign out_frame_length  = out_res.frame_length;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_checksum_ok   = out_res.checksum_ok;

  // sync flag only moves on a second checksum byte
  a_sync_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    (synced_r != $past(synced_r)) |-> $past(acc && (phase_r == ubx_pkg::PH_CHECK2)))
    else $error("synchronized flag changed outside frame end");

  // payload index never reaches the declared length
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ubx_pkg::PH_PAYLOAD) |-> (pos_r < len_r))
    else $error("payload position past declared length");

  // header and reject come from the second length byte only
  a_header_src: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && ((res.kind == ubx_pkg::KIND_HEADER) ||
                  (res.kind == ubx_pkg::KIND_REJECT)))
      |-> (phase_r == ubx_pkg::PH_LEN_HI))
    else $error("header result outside length phase");

endmodule

// ===== rtl/ubx_out_skid.sv =====
// ----------------------------------------------------------------------------
// ubx_out_skid
// two-entry output buffer: output register plus skid register, so the
// upstream ready is a flop and never waits on the downstream ready
// ----------------------------------------------------------------------------
module ubx_out_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ubx_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output ubx_pkg::result_t out_data
);

  logic             main_v_r, main_v_nxt;
  logic             skid_v_r, skid_v_nxt;
  ubx_pkg::result_t main_d_r, main_d_nxt;
  ubx_pkg::result_t skid_d_r, skid_d_nxt;
  logic             pop;

  assign pop       = main_v_r && out_ready;
  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      // no push possible while the skid holds an item
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_d_nxt = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_d_nxt = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  // skid only fills behind a held output
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid holds an item with output register empty");

  a_stalled_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !out_ready) |=> (main_v_r && $stable(main_d_r)))
    else $error("stalled result lost or changed");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (main_v_r && !skid_v_r))
    else $error("skid item not moved to output register");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for ubx_frame_parser: a byte-level parser tracker
// predicts every header, payload, frame-end and reject item, and a checker
// compares each result item field by field in order of arrival
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 400_000; // far above the slowest legal run
  localparam int DRAIN_CYCLES = 6;       // output register plus skid slot
  localparam int STALL_CYCLES = 300;     // long receiver hold-off
  localparam int SHOW_LIMIT   = 100;     // keep the log short on a bad build

  // ways a generated frame can be damaged
  typedef enum int {FLAW_NONE, FLAW_SUM_A, FLAW_SUM_B, FLAW_TRUNCATE} flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_msg_class;
  logic [7:0]  out_msg_id;
  logic [15:0] out_frame_length;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_payload_index;
  logic        out_checksum_ok;

  // parser tracker state, mirrors what the block holds
  ubx_pkg::phase_t trk_phase;
  logic [7:0]      trk_class, trk_msg, trk_sum_a, trk_sum_b, trk_check1;
  logic [15:0]     trk_len, trk_pos, trk_limit;
  bit              trk_synced;

  ubx_pkg::result_t awaited_results[$];   // predicted items not yet seen on out_

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // receiver hold-off: bump stall_request to start one
  int stall_request = 0;
  int stall_seen = 0;
  int stall_left = 0;

  // bookkeeping
  int cycle_count = 0;
  int input_stalls = 0;
  int mismatches = 0;
  int active_items = 0;
  int limit_writes = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  int good_ends = 0;

  ubx_frame_parser DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_msg_class     (out_msg_class),
    .out_msg_id        (out_msg_id),
    .out_frame_length  (out_frame_length),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_checksum_ok   (out_checksum_ok)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // parser tracker
  // ---------------------------------------------------------------------------

  function automatic void reset_tracker();
    trk_phase  = ubx_pkg::PH_SYNC1;
    trk_class  = '0;
    trk_msg    = '0;
    trk_len    = '0;
    trk_pos    = '0;
    trk_sum_a  = '0;
    trk_sum_b  = '0;
    trk_check1 = '0;
    trk_synced = 1'b0;
    trk_limit  = ubx_pkg::LIMIT_RESET;
  endfunction

  // 8-bit fletcher step, both sums wrap at 256
  function automatic void fold_sum(input logic [7:0] c);
    trk_sum_a = trk_sum_a + c;
    trk_sum_b = trk_sum_b + trk_sum_a;
  endfunction

  // every result carries the current frame's class, id and length
  function automatic ubx_pkg::result_t stamp_result(input logic [1:0] kind,
                                                    input logic [7:0] data,
                                                    input logic [15:0] pos,
                                                    input logic ok);
    ubx_pkg::result_t r;
    r.kind          = kind;
    r.msg_class     = trk_class;
    r.msg_id        = trk_msg;
    r.frame_length  = trk_len;
    r.payload_byte  = data;
    r.payload_index = pos;
    r.checksum_ok   = ok;
    return r;
  endfunction

  // advance the tracker by one accepted byte; returns 1 when a result is due
  function automatic bit parse_rx_byte(input logic [7:0] c, output ubx_pkg::result_t r);
    bit emitted;
    bit ok;
    emitted = 1'b0;
    r = '0;
    // bytes dropped while hunting do not count as traffic
    if (!(trk_phase == ubx_pkg::PH_SYNC1 && c != ubx_pkg::SYNC_CHAR_1)) active_items++;
    case (trk_phase)
      ubx_pkg::PH_SYNC2: begin
        // anything but the second sync char, even another first one, restarts the hunt
        if (c == ubx_pkg::SYNC_CHAR_2) trk_phase = ubx_pkg::PH_CLASS;
        else trk_phase = ubx_pkg::PH_SYNC1;
      end
      ubx_pkg::PH_CLASS: begin
        trk_class = c;
        trk_sum_a = '0;
        trk_sum_b = '0;
        fold_sum(c);
        trk_phase = ubx_pkg::PH_MSG;
      end
      ubx_pkg::PH_MSG: begin
        trk_msg = c;
        fold_sum(c);
        trk_phase = ubx_pkg::PH_LEN_LO;
      end
      ubx_pkg::PH_LEN_LO: begin
        trk_len = {8'h00, c};
        fold_sum(c);
        trk_phase = ubx_pkg::PH_LEN_HI;
      end
      ubx_pkg::PH_LEN_HI: begin
        trk_len[15:8] = c;
        trk_pos = '0;
        fold_sum(c);
        // the limit only applies while not synchronized
        if (!trk_synced && trk_len > trk_limit) begin
          r = stamp_result(ubx_pkg::KIND_REJECT, 8'h00, 16'h0000, 1'b0);
          trk_phase = ubx_pkg::PH_SYNC1;
        end else begin
          r = stamp_result(ubx_pkg::KIND_HEADER, 8'h00, 16'h0000, 1'b0);
          if (trk_len != 16'h0000) trk_phase = ubx_pkg::PH_PAYLOAD;
          else trk_phase = ubx_pkg::PH_CHECK1;
        end
        emitted = 1'b1;
      end
      ubx_pkg::PH_PAYLOAD: begin
        r = stamp_result(ubx_pkg::KIND_PAYLOAD, c, trk_pos, 1'b0);
        emitted = 1'b1;
        fold_sum(c);
        trk_pos = trk_pos + 16'd1;
        if (trk_pos >= trk_len) trk_phase = ubx_pkg::PH_CHECK1;
      end
      ubx_pkg::PH_CHECK1: begin
        trk_check1 = c;
        trk_phase = ubx_pkg::PH_CHECK2;
      end
      ubx_pkg::PH_CHECK2: begin
        ok = (trk_check1 == trk_sum_a) && (c == trk_sum_b);
        trk_synced = ok;
        if (ok) good_ends++;
        r = stamp_result(ubx_pkg::KIND_END, 8'h00, 16'h0000, ok);
        emitted = 1'b1;
        trk_phase = ubx_pkg::PH_SYNC1;
      end
      default: begin
        if (c == ubx_pkg::SYNC_CHAR_1) trk_phase = ubx_pkg::PH_SYNC2;
        else trk_phase = ubx_pkg::PH_SYNC1;
      end
    endcase
    if (emitted) kind_seen[r.kind]++;
    return emitted;
  endfunction

  // ---------------------------------------------------------------------------
  // shared stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    // only the first ones are printed, all are counted
    if (mismatches <= SHOW_LIMIT)
      $display("mismatch at cycle %0d: %s is %0h, expected %0h", cycle_count, what, got, want);
  endtask

  // offer one byte, hold it until accepted, then let the tracker see it
  task automatic send_byte(input logic [7:0] b);
    ubx_pkg::result_t r;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (parse_rx_byte(b, r)) awaited_results.push_back(r);
  endtask

  // stop offering and wait until every predicted item came back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only ever called while the block is idle
  task automatic write_limit(input logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trk_limit = v;
    limit_writes++;
  endtask

  // random byte with the sync chars made common
  function automatic logic [7:0] pick_byte();
    int p;
    p = $urandom_range(99);
    if (p < 10) return ubx_pkg::SYNC_CHAR_1;
    if (p < 20) return ubx_pkg::SYNC_CHAR_2;
    return 8'($urandom_range(255));
  endfunction

  // mostly short payloads, a few longer ones
  function automatic logic [15:0] pick_length();
    int p;
    p = $urandom_range(99);
    if (p < 80) return 16'($urandom_range(16));
    if (p < 95) return 16'($urandom_range(64, 17));
    return 16'($urandom_range(300, 65));
  endfunction

  // feed random bytes until the tracker is hunting again
  task automatic flush_to_hunt();
    while (trk_phase != ubx_pkg::PH_SYNC1) send_byte(8'($urandom_range(255)));
  endtask

  // one frame from the hunting state; payload is skipped when the header is rejected
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg,
                            input logic [15:0] len, input flaw_t flaw);
    logic [7:0] hdr [4];
    logic [7:0] sa, sb, b;
    int stop_at;
    int i;
    hdr[0] = cls;
    hdr[1] = msg;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    sa = '0;
    sb = '0;
    stop_at = (flaw == FLAW_TRUNCATE) ? $urandom_range(int'(len)) : int'(len) + 1;
    send_byte(ubx_pkg::SYNC_CHAR_1);
    send_byte(ubx_pkg::SYNC_CHAR_2);
    for (i = 0; i < 4; i++) begin
      send_byte(hdr[i]);
      sa = sa + hdr[i];
      sb = sb + sa;
    end
    if (trk_phase == ubx_pkg::PH_SYNC1) return;
    for (i = 0; i < int'(len); i++) begin
      if (i == stop_at) return;
      b = pick_byte();
      send_byte(b);
      sa = sa + b;
      sb = sb + sa;
    end
    if (flaw == FLAW_TRUNCATE) return;
    send_byte((flaw == FLAW_SUM_A) ? sa ^ 8'($urandom_range(255, 1)) : sa);
    send_byte((flaw == FLAW_SUM_B) ? sb ^ 8'($urandom_range(255, 1)) : sb);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a repeated first sync char must not start a frame; then an empty frame
  // whose length equals a zero limit, which also brings the parser in sync
  task automatic test_sync_hunting();
    send_byte(ubx_pkg::SYNC_CHAR_1);
    send_byte(ubx_pkg::SYNC_CHAR_1);
    send_byte(ubx_pkg::SYNC_CHAR_2);
    send_frame(8'hFF, 8'h00, 16'h0000, FLAW_NONE);
    wait_idle();
  endtask

  // no limit once synced; a bad checksum drops sync; then a maximal
  // length is rejected against the zero limit
  task automatic test_length_limit();
    send_frame(8'h00, 8'hFF, 16'h0001, FLAW_SUM_B);
    send_frame(8'h5A, 8'hA5, 16'hFFFF, FLAW_NONE);
    wait_idle();
  endtask

  // mostly well-formed frames with random content, the rest damaged or noise
  task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
    int goal, pick, k;
    flaw_t flaw;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    goal = active_items + n_items;
    while (active_items < goal) begin
      flush_to_hunt();
      pick = $urandom_range(99);
      if (pick < 70) begin
        flaw = FLAW_NONE;
        if ($urandom_range(99) < 15) flaw = $urandom_range(1) ? FLAW_SUM_A : FLAW_SUM_B;
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), pick_length(), flaw);
      end else if (pick < 80) begin
        k = $urandom_range(6, 1);
        repeat (k) send_byte(pick_byte());
      end else if (pick < 88) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), pick_length(),
                   FLAW_TRUNCATE);
      end else if (pick < 94) begin
        // broken sync pair, the second byte is never the right one
        send_byte(ubx_pkg::SYNC_CHAR_1);
        if ($urandom_range(1)) send_byte(ubx_pkg::SYNC_CHAR_1);
        else send_byte(8'($urandom_range(ubx_pkg::SYNC_CHAR_2 - 1)));
      end else if (!trk_synced && trk_limit != 16'hFFFF) begin
        // oversized header while out of sync, rejected before any payload
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(65535, int'(trk_limit) + 1)), FLAW_NONE);
      end else begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), pick_length(), FLAW_NONE);
      end
    end
    wait_idle();
  endtask

  // receiver holds off for a long stretch while frames keep coming, so the
  // output and skid registers fill and in_ready has to drop
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request++;
    repeat (10) begin
      flush_to_hunt();
      send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                 16'($urandom_range(6)), FLAW_NONE);
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // result checker and receiver ready
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    ubx_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected item of kind", out_kind, 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", out_kind, want.kind);
        if (out_msg_class !== want.msg_class)
          report_mismatch("msg_class", out_msg_class, want.msg_class);
        if (out_msg_id !== want.msg_id)
          report_mismatch("msg_id", out_msg_id, want.msg_id);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        if (out_payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", out_payload_byte, want.payload_byte);
        if (out_payload_index !== want.payload_index)
          report_mismatch("payload_index", out_payload_index, want.payload_index);
        if (out_checksum_ok !== want.checksum_ok)
          report_mismatch("checksum_ok", out_checksum_ok, want.checksum_ok);
      end
    end
    // a new hold-off request starts a fresh count of stalled cycles
    if (stall_request != stall_seen) begin
      stall_seen = stall_request;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // cycle count, input stall count and the overall time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && !in_ready && rst_n) input_stalls <= input_stalls + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still awaited",
               cycle_count, awaited_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_tracker();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, lowest limit
    write_limit(16'h0000);
    test_sync_hunting();
    test_length_limit();

    // sender mostly busy, receiver mostly stalled, no limit at all
    write_limit(16'hFFFF);
    test_random_traffic(520, 13, 82);

    // sender sparse, receiver eager, tight limit so rejects are common
    write_limit(16'($urandom_range(64)));
    test_random_traffic(520, 82, 13);

    // back to the reset limit, full rate on both sides
    write_limit(ubx_pkg::LIMIT_RESET);
    test_random_traffic(520, 0, 0);

    write_limit(16'($urandom_range(65535)));
    test_backpressure();

    $display("covered %0d parser bytes under %0d limit settings, input stalled %0d cycles",
             active_items, limit_writes, input_stalls);
    $display("checked %0d headers, %0d payload bytes, %0d frame ends (%0d good), %0d rejects",
             kind_seen[ubx_pkg::KIND_HEADER], kind_seen[ubx_pkg::KIND_PAYLOAD],
             kind_seen[ubx_pkg::KIND_END], good_ends, kind_seen[ubx_pkg::KIND_REJECT]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
